// ----- design/rhc_pkg.sv -----
// Shared constants and types for the RGB to HSV converter.
package rhc_pkg;

  // Component and result widths.
  localparam int unsigned COMP_W     = 8;
  localparam int unsigned HUE_W      = 15;
  localparam int unsigned SAT_W      = 16;
  localparam int unsigned HUE_FRAC   = 6;
  localparam int unsigned SAT_FRAC   = 15;

  // Every quotient fits in 16 bits: saturation reaches 2^15, hue stays below 360 * 2^6.
  localparam int unsigned QUO_W      = 16;
  localparam int unsigned DEN_W      = COMP_W;
  localparam int unsigned NUM_W      = DEN_W + QUO_W;

  // Hue numerator before scaling stays below 360 * (max - min).
  localparam int unsigned TOT_W      = COMP_W + 9;

  // Hue branch offsets and the wrap, in degrees.
  localparam int unsigned DEG_60     = 60;
  localparam int unsigned DEG_120    = 120;
  localparam int unsigned DEG_240    = 240;
  localparam int unsigned DEG_360    = 360;

  // Cycles from an accepted request to its result strobe.
  localparam int unsigned LATENCY    = QUO_W + 3;

  // Upper bounds of the result fields.
  localparam int unsigned HUE_LIMIT  = DEG_360 << HUE_FRAC;
  localparam int unsigned SAT_ONE    = 1 << SAT_FRAC;

  // Which component is largest.
  typedef enum logic [1:0] {
    BrRed   = 2'd0,
    BrGreen = 2'd1,
    BrBlue  = 2'd2
  } branch_e;

  // One division in flight: divisor, partial remainder, and a word that holds
  // the unused dividend bits on top and the quotient bits found so far below.
  typedef struct packed {
    logic [DEN_W-1:0] den;
    logic [DEN_W-1:0] rem;
    logic [QUO_W-1:0] bits;
  } lane_t;

  // Pixel data that rides along the divider chain.
  typedef struct packed {
    logic [COMP_W-1:0] brightness;
    logic              gray;
    logic              black;
  } side_t;

endpackage

// ----- design/rhc_prep.sv -----
// Front end: max, min, hue branch and numerators, set up as two divider lanes.
module rhc_prep (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [rhc_pkg::COMP_W-1:0]  red_i,
  input  logic [rhc_pkg::COMP_W-1:0]  green_i,
  input  logic [rhc_pkg::COMP_W-1:0]  blue_i,
  output logic                        valid_o,
  output rhc_pkg::lane_t              hue_o,
  output rhc_pkg::lane_t              sat_o,
  output rhc_pkg::side_t              side_o
);
  import rhc_pkg::*;

  localparam logic signed [TOT_W:0] Sixty = (TOT_W+1)'(DEG_60);

  // First stage registers.
  logic                     valid1_q;
  logic [COMP_W-1:0]        max_q, delta_q;
  logic signed [COMP_W:0]   num_q;
  branch_e                  branch_q;

  logic [COMP_W-1:0]        max_d, min_d;
  logic signed [COMP_W:0]   num_d;
  branch_e                  branch_d;

  // Largest component picks the branch; red wins ties over green, green over blue.
  always_comb begin
    if (red_i >= green_i && red_i >= blue_i) begin
      branch_d = BrRed;
      max_d    = red_i;
      num_d    = $signed({1'b0, green_i}) - $signed({1'b0, blue_i});
    end else if (green_i >= blue_i) begin
      branch_d = BrGreen;
      max_d    = green_i;
      num_d    = $signed({1'b0, blue_i}) - $signed({1'b0, red_i});
    end else begin
      branch_d = BrBlue;
      max_d    = blue_i;
      num_d    = $signed({1'b0, red_i}) - $signed({1'b0, green_i});
    end
    min_d = red_i;
    if (green_i < min_d) min_d = green_i;
    if (blue_i < min_d) min_d = blue_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    max_q    <= max_d;
    delta_q  <= max_d - min_d;
    num_q    <= num_d;
    branch_q <= branch_d;
  end

  // Second stage: hue numerator in degrees times delta, wrapped when negative.
  logic [TOT_W:0]          dext;
  logic [TOT_W:0]          base;
  logic signed [TOT_W:0]   prod;
  logic signed [TOT_W:0]   total_s;
  logic signed [TOT_W:0]   wrapped;
  logic [TOT_W-1:0]        total;
  logic [NUM_W-1:0]        hue_num, sat_num;
  lane_t                   hue_d, sat_d;
  side_t                   side_d;

  always_comb begin
    dext = (TOT_W+1)'(delta_q);
    unique case (branch_q)
      BrRed:   base = '0;
      BrGreen: base = dext * (TOT_W+1)'(DEG_120);
      BrBlue:  base = dext * (TOT_W+1)'(DEG_240);
      default: base = '0;
    endcase
    prod    = (TOT_W+1)'(num_q) * Sixty;
    total_s = $signed(base) + prod;
    wrapped = total_s[TOT_W] ? total_s + $signed(dext * (TOT_W+1)'(DEG_360)) : total_s;
    total   = wrapped[TOT_W-1:0];

    hue_num = NUM_W'(total) << HUE_FRAC;
    sat_num = NUM_W'(delta_q) << SAT_FRAC;

    hue_d.den  = delta_q;
    hue_d.rem  = hue_num[NUM_W-1:QUO_W];
    hue_d.bits = hue_num[QUO_W-1:0];
    sat_d.den  = max_q;
    sat_d.rem  = sat_num[NUM_W-1:QUO_W];
    sat_d.bits = sat_num[QUO_W-1:0];

    side_d.brightness = max_q;
    side_d.gray       = (delta_q == '0);
    side_d.black      = (max_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hue_o  <= hue_d;
    sat_o  <= sat_d;
    side_o <= side_d;
  end

endmodule

// ----- design/rhc_div_cell.sv -----
// One divider cell: a restoring step for the hue and saturation quotients.
module rhc_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  rhc_pkg::lane_t  hue_i,
  input  rhc_pkg::lane_t  sat_i,
  input  rhc_pkg::side_t  side_i,
  output logic            valid_o,
  output rhc_pkg::lane_t  hue_o,
  output rhc_pkg::lane_t  sat_o,
  output rhc_pkg::side_t  side_o
);
  import rhc_pkg::*;

  // Bring down the next dividend bit, subtract the divisor if it fits, and
  // shift the new quotient bit in at the bottom.
  function automatic lane_t div_step(lane_t l);
    logic [DEN_W:0] t;
    logic [DEN_W:0] diff;
    logic           ge;
    lane_t          r;
    t      = {l.rem, l.bits[QUO_W-1]};
    diff   = t - {1'b0, l.den};
    ge     = (t >= {1'b0, l.den});
    r.den  = l.den;
    r.rem  = ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
    r.bits = {l.bits[QUO_W-2:0], ge};
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    hue_o  <= div_step(hue_i);
    sat_o  <= div_step(sat_i);
    side_o <= side_i;
  end

endmodule

// ----- design/rgb_to_hsv_converter.sv -----
// Top level of the RGB to HSV converter: front end, divider cell chain, result register.
//
// The converter takes one pixel per clock: busy_o never rises, so a request is
// taken whenever start_i is high, and its hue, saturation and brightness appear
// with a one-cycle done_o strobe after it has passed two front-end stages,
// sixteen divider cells that each find one quotient bit of both divisions, and
// one result register. Results keep request order and cannot be held off, so
// the receiver must take each one in the cycle it is shown. The block keeps no
// state beyond its pipeline.
module rgb_to_hsv_converter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [rhc_pkg::COMP_W-1:0]  red_i,
  input  logic [rhc_pkg::COMP_W-1:0]  green_i,
  input  logic [rhc_pkg::COMP_W-1:0]  blue_i,
  output logic                        done_o,
  output logic [rhc_pkg::HUE_W-1:0]   hue_o,
  output logic [rhc_pkg::SAT_W-1:0]   saturation_o,
  output logic [rhc_pkg::COMP_W-1:0]  brightness_o
);
  import rhc_pkg::*;

  // The pipeline never stalls.
  assign busy_o = 1'b0;

  logic   valid_s [QUO_W+1];
  lane_t  hue_s   [QUO_W+1];
  lane_t  sat_s   [QUO_W+1];
  side_t  side_s  [QUO_W+1];

  // Front end.
  rhc_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .valid_o (valid_s[0]),
    .hue_o   (hue_s[0]),
    .sat_o   (sat_s[0]),
    .side_o  (side_s[0])
  );

  // Divider chain, one quotient bit per cell.
  for (genvar i = 0; i < QUO_W; i++) begin : g_cell
    rhc_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_s[i]),
      .hue_i   (hue_s[i]),
      .sat_i   (sat_s[i]),
      .side_i  (side_s[i]),
      .valid_o (valid_s[i+1]),
      .hue_o   (hue_s[i+1]),
      .sat_o   (sat_s[i+1]),
      .side_o  (side_s[i+1])
    );
  end

  // Result register; gray pixels have no hue and black pixels no saturation.
  logic              done_q;
  logic [HUE_W-1:0]  hue_q;
  logic [SAT_W-1:0]  sat_q;
  logic [COMP_W-1:0] bright_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_s[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    hue_q    <= side_s[QUO_W].gray  ? '0 : hue_s[QUO_W].bits[HUE_W-1:0];
    sat_q    <= side_s[QUO_W].black ? '0 : sat_s[QUO_W].bits[SAT_W-1:0];
    bright_q <= side_s[QUO_W].brightness;
  end

  assign done_o       = done_q;
  assign hue_o        = hue_q;
  assign saturation_o = sat_q;
  assign brightness_o = bright_q;

  // Every request gives a result after the fixed latency, and no result comes unasked.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##LATENCY done_o)
    else $error("request did not produce a result on time");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result without a matching request");

  // Quotients stay in range.
  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> 32'(hue_o) < HUE_LIMIT)
    else $error("hue out of range");

  a_sat_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> 32'(saturation_o) <= SAT_ONE)
    else $error("saturation out of range");

  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && brightness_o == '0 |-> saturation_o == '0 && hue_o == '0)
    else $error("black pixel with nonzero hue or saturation");

endmodule
